[design/swm_pkg.sv]
// swm_pkg: shared sizes, types and constants of the sliding window median filter
// used by swm_cell and sliding_window_median; depends on nothing
`timescale 1ns / 1ps

package swm_pkg;

    // window storage and sample format
    localparam int MAX_WINDOW  = 64;
    localparam int SAMPLE_BITS = 32;
    localparam int IDX_W       = $clog2(MAX_WINDOW);
    localparam int CNT_W       = $clog2(MAX_WINDOW + 1);

    // window size register
    localparam int         WS_W     = 7;
    localparam logic [6:0] WS_RESET = 7'd3;

    // one sorted entry held by a cell
    typedef struct packed {
        logic                          valid;
        logic [IDX_W-1:0]              age;
        logic signed [SAMPLE_BITS-1:0] value;
    } t_entry;

    // control broadcast to every cell
    typedef struct packed {
        logic                          load;
        logic                          clear;
        logic                          full;
        logic [IDX_W-1:0]              oldest_age;
        logic signed [SAMPLE_BITS-1:0] sample;
    } t_ctrl;

endpackage

[design/swm_cell.sv]
// swm_cell: one slot of the sorted window, with the sample's age
// depends on swm_pkg; neighbors pass entries and compare flags both ways
`timescale 1ns / 1ps

module swm_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  swm_pkg::t_ctrl i_ctrl,
    input  swm_pkg::t_entry i_left,
    input  logic           i_left_gt,
    input  swm_pkg::t_entry i_right,
    input  logic           i_right_gt,
    input  logic           i_rm_left,
    output swm_pkg::t_entry o_entry,
    output logic           o_gt,
    output logic           o_rm_seen
);

    logic                                  r_valid;
    logic [swm_pkg::IDX_W-1:0]             r_age;
    logic signed [swm_pkg::SAMPLE_BITS-1:0] r_value;

    swm_pkg::t_entry own;
    swm_pkg::t_entry v_cur;
    swm_pkg::t_entry v_prev;
    swm_pkg::t_entry src;
    swm_pkg::t_entry n_entry;
    logic            rm_here;
    logic            shift_l;
    logic            vg_cur;
    logic            vg_prev;

    assign own = '{valid: r_valid, age: r_age, value: r_value};

    // empty slots sort above every sample
    assign o_gt = !r_valid || ($signed(r_value) > $signed(i_ctrl.sample));

    // the oldest sample leaves once the window is full
    assign rm_here   = i_ctrl.full && r_valid && (r_age == i_ctrl.oldest_age);
    assign shift_l   = i_rm_left || rm_here;
    assign o_rm_seen = shift_l;

    // list after removal, seen at this slot and the one to the left
    assign v_cur   = shift_l   ? i_right    : own;
    assign vg_cur  = shift_l   ? i_right_gt : o_gt;
    assign v_prev  = i_rm_left ? own        : i_left;
    assign vg_prev = i_rm_left ? o_gt       : i_left_gt;

    // insertion: move right, take the new sample, or hold
    always_comb begin
        src = vg_cur ? v_prev : v_cur;
        n_entry = '{valid: src.valid,
                    age:   swm_pkg::IDX_W'(src.age + 1'b1),
                    value: src.value};
        if (vg_cur && !vg_prev) begin
            n_entry = '{valid: 1'b1, age: '0, value: i_ctrl.sample};
        end
    end

    // occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctrl.clear) begin
            r_valid <= 1'b0;
        end else if (i_ctrl.load) begin
            r_valid <= n_entry.valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_age   <= n_entry.age;
            r_value <= n_entry.value;
        end
    end

    assign o_entry = own;

endmodule

[design/sliding_window_median.sv]
// sliding_window_median: top level, a row of sorted cells plus handshake and output register
// depends on swm_pkg and swm_cell
//
// channel   dir  handshake            payload
// s_*       in   s_tvalid/s_tready    s_tdata[31:0] = sample
// m_*       out  m_tvalid/m_tready    m_tdata[31:0] = median
// cfg       in   i_cfg_we             i_cfg_wdata[6:0] = window_size
//
// one item per cycle unless the input stalls: the cell row inserts the new sample and,
// once the window is full, drops the oldest as the item is accepted; with a full window
// the median waits in one pending slot until the output register is free, and input stalls
// only when both are full. reset and a window_size write empty the row at once, no sweep.
`timescale 1ns / 1ps

module sliding_window_median (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [6:0]  i_cfg_wdata,  // window_size
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,      // [31:0] sample
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata       // [31:0] median
);

    localparam int N = swm_pkg::MAX_WINDOW;

    logic [swm_pkg::WS_W-1:0]  r_ws;
    logic [swm_pkg::CNT_W-1:0] r_fill;
    logic [swm_pkg::CNT_W-1:0] n_fill;
    logic                      r_pend;
    logic                      n_pend;
    logic                      r_out_valid;
    logic [31:0]               r_out_data;

    logic [swm_pkg::CNT_W-1:0] k;
    logic [swm_pkg::IDX_W-1:0] k_m1;
    logic [swm_pkg::IDX_W-1:0] mid;
    logic                      full;
    logic                      accept;
    logic                      load;
    logic                      emit;
    swm_pkg::t_ctrl            ctrl;

    swm_pkg::t_entry cell_e   [N];
    logic            cell_gt  [N];
    logic            cell_rm  [N];
    swm_pkg::t_entry left_e   [N];
    logic            left_gt  [N];
    swm_pkg::t_entry right_e  [N];
    logic            right_gt [N];
    logic            rm_left  [N];
    logic [N-1:0]    valid_vec;

    // effective window size, 1 up to the row length
    always_comb begin
        if (r_ws == '0) begin
            k = swm_pkg::CNT_W'(1);
        end else if (swm_pkg::CNT_W'(r_ws) > swm_pkg::CNT_W'(N)) begin
            k = swm_pkg::CNT_W'(N);
        end else begin
            k = swm_pkg::CNT_W'(r_ws);
        end
    end
    assign k_m1 = swm_pkg::IDX_W'(k - 1'b1);
    assign mid  = k_m1 >> 1;
    assign full = (r_fill == k);

    // handshake
    assign load     = r_pend && (!r_out_valid || m_tready);
    assign s_tready = !r_pend || load;
    assign accept   = s_tvalid && s_tready;
    assign emit     = full || (swm_pkg::CNT_W'(r_fill + 1'b1) == k);

    always_comb begin
        n_fill = r_fill;
        n_pend = r_pend && !load;
        if (accept) begin
            n_pend = emit;
            if (!full) begin
                n_fill = swm_pkg::CNT_W'(r_fill + 1'b1);
            end
        end
    end

    // control broadcast to the row
    assign ctrl = '{load:       accept,
                    clear:      i_cfg_we,
                    full:       full,
                    oldest_age: k_m1,
                    sample:     $signed(s_tdata)};

    // the cell row
    for (genvar g = 0; g < N; g++) begin : g_cell
        if (g == 0) begin : g_first
            assign left_e[g]  = '0;
            assign left_gt[g] = 1'b0;
            assign rm_left[g] = 1'b0;
        end else begin : g_mid
            assign left_e[g]  = cell_e[g-1];
            assign left_gt[g] = cell_gt[g-1];
            assign rm_left[g] = cell_rm[g-1];
        end
        if (g == N - 1) begin : g_last
            assign right_e[g]  = '0;
            assign right_gt[g] = 1'b1;
        end else begin : g_inner
            assign right_e[g]  = cell_e[g+1];
            assign right_gt[g] = cell_gt[g+1];
        end
        assign valid_vec[g] = cell_e[g].valid;

        swm_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctrl     (ctrl),
            .i_left     (left_e[g]),
            .i_left_gt  (left_gt[g]),
            .i_right    (right_e[g]),
            .i_right_gt (right_gt[g]),
            .i_rm_left  (rm_left[g]),
            .o_entry    (cell_e[g]),
            .o_gt       (cell_gt[g]),
            .o_rm_seen  (cell_rm[g])
        );
    end

    // window size and fill state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ws   <= swm_pkg::WS_RESET;
            r_fill <= '0;
            r_pend <= 1'b0;
        end else begin
            r_pend <= n_pend;
            if (i_cfg_we) begin
                r_ws   <= i_cfg_wdata;
                r_fill <= '0;
            end else begin
                r_fill <= n_fill;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load) begin
            r_out_valid <= 1'b1;
        end else if (m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_data <= cell_e[mid].value;
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = r_out_data;

    // occupied cells match the fill count
    a_fill_match : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(valid_vec) == int'(r_fill))
        else $error("cell occupancy differs from fill count");

    // fill count never passes the window size
    a_fill_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= k)
        else $error("fill count above window size");

    // a full window always has one sample to drop
    a_full_drop : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        full |-> cell_rm[N-1])
        else $error("full window without an oldest sample");

    // an item on a full window leaves a result pending
    a_full_emit : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && full && !i_cfg_we) |=> r_pend)
        else $error("full window item gave no result");

endmodule
